FILE: rtl/sac_lru_pkg.sv
package sac_lru_pkg;

    // default sizes of the tag store
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_MAX_SETS  = 256;
    localparam int DEF_ADDR_BITS = 32;

    // fixed field widths
    localparam int ACT_W     = 2;
    localparam int IN_ADDR_W = 32;
    localparam int CNT_W     = 32;
    localparam int OUT_WAY_W = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd4;
    localparam logic [CFG_W-1:0] RST_SET_BITS    = 4'd4;
    localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd4;

    // controller to datapath commands
    typedef struct packed {
        logic capture;        // word accepted: latch tag, read the set row
        logic init_wr;        // reset pass: write initial row at sweep pointer
        logic clr_wr;         // clear pass: zero valid row at sweep pointer
        logic commit_access;  // write back the set, update counters, load result
        logic commit_plain;   // load result of a no-op or clear word
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic act_access;     // incoming word is an access
        logic act_clear;      // incoming word is a clear
        logic sweep_last;     // sweep pointer at the last set
        logic out_free;       // result register can take a new word
    } dp_status_t;

endpackage

FILE: rtl/sac_lru_ctrl.sv
module sac_lru_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sac_lru_pkg::dp_status_t status,
    output sac_lru_pkg::dp_cmd_t    cmd
);
    import sac_lru_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    // state and ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            s_ready_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_INIT: begin
                    if (status.sweep_last) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        s_ready_reg <= 1'b0;
                        if (status.act_access) begin
                            state_reg <= ST_LOOKUP;
                        end else if (status.act_clear) begin
                            state_reg <= ST_SWEEP;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_LOOKUP: begin
                    if (status.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_SWEEP: begin
                    if (status.sweep_last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (status.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_INIT;
                    s_ready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;

    // command decode
    always_comb begin
        cmd               = '0;
        cmd.capture       = (state_reg == ST_IDLE) && s_valid;
        cmd.init_wr       = (state_reg == ST_INIT);
        cmd.clr_wr        = (state_reg == ST_SWEEP);
        cmd.commit_access = (state_reg == ST_LOOKUP) && status.out_free;
        cmd.commit_plain  = (state_reg == ST_FINISH) && status.out_free;
    end

endmodule

FILE: rtl/sac_lru_dp.sv
module sac_lru_dp #(
    parameter int MAX_WAYS  = sac_lru_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS  = sac_lru_pkg::DEF_MAX_SETS,
    parameter int ADDR_BITS = sac_lru_pkg::DEF_ADDR_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sac_lru_pkg::dp_cmd_t                 cmd,
    output sac_lru_pkg::dp_status_t              status,
    input  logic [sac_lru_pkg::ACT_W-1:0]        s_action,
    input  logic [sac_lru_pkg::IN_ADDR_W-1:0]    s_address,
    input  logic                                cfg_wr_en,
    input  logic [sac_lru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sac_lru_pkg::CFG_W-1:0]        cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [sac_lru_pkg::OUT_WAY_W-1:0]    m_way_used,
    output logic [sac_lru_pkg::CNT_W-1:0]        m_miss_count,
    output logic [sac_lru_pkg::CNT_W-1:0]        m_reference_count
);
    import sac_lru_pkg::*;

    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SB_MAX   = $clog2(MAX_SETS + 1) - 1;
    localparam int LAST_SET = MAX_SETS - 1;

    typedef logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_row_t;
    typedef logic [MAX_WAYS-1:0][AGE_W-1:0]     age_row_t;
    typedef logic [MAX_WAYS-1:0]                valid_row_t;

    // set rows: one row per set, all ways side by side
    tag_row_t   tag_mem   [MAX_SETS];
    valid_row_t valid_mem [MAX_SETS];
    age_row_t   age_mem   [MAX_SETS];

    logic [CFG_W-1:0]     offset_bits_reg;
    logic [CFG_W-1:0]     set_bits_reg;
    logic [CFG_W-1:0]     ways_reg;

    logic [SET_W-1:0]     sweep_reg;
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    tag_row_t             rd_tag_reg;
    valid_row_t           rd_valid_reg;
    age_row_t             rd_age_reg;

    logic [CNT_W-1:0]     misses_reg;
    logic [CNT_W-1:0]     misses_next;
    logic [CNT_W-1:0]     refs_reg;
    logic [CNT_W-1:0]     refs_next;

    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic [OUT_WAY_W-1:0] m_way_used_reg;
    logic [CNT_W-1:0]     m_miss_count_reg;
    logic [CNT_W-1:0]     m_reference_count_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= RST_OFFSET_BITS;
            set_bits_reg    <= RST_SET_BITS;
            ways_reg        <= RST_WAYS_IN_USE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                REG_SET_BITS:    set_bits_reg    <= cfg_data;
                REG_WAYS_IN_USE: ways_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // address split into set index and tag
    logic [CFG_W-1:0]     eff_sb;
    logic [ADDR_BITS-1:0] addr_in;
    logic [ADDR_BITS-1:0] shifted;
    logic [ADDR_BITS-1:0] set_mask;
    logic [31:0]          set_wide;
    logic [SET_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag_in;

    always_comb begin
        eff_sb   = (set_bits_reg > CFG_W'(SB_MAX)) ? CFG_W'(SB_MAX) : set_bits_reg;
        addr_in  = s_address[ADDR_BITS-1:0];
        shifted  = addr_in >> offset_bits_reg;
        set_mask = (ADDR_BITS'(1) << eff_sb) - ADDR_BITS'(1);
        set_wide = 32'(shifted & set_mask);
        set_idx  = set_wide[SET_W-1:0];
        tag_in   = addr_in >> (5'(offset_bits_reg) + 5'(eff_sb));
    end

    // ways in use
    logic [4:0]          eff_ways;
    logic [MAX_WAYS-1:0] in_use;

    always_comb begin
        if (ways_reg == '0) begin
            eff_ways = 5'd1;
        end else if (5'(ways_reg) > 5'(MAX_WAYS)) begin
            eff_ways = 5'(MAX_WAYS);
        end else begin
            eff_ways = 5'(ways_reg);
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = 5'(w) < eff_ways;
        end
    end

    // tag compare, victim pick and lru update on the read row
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] victim;
    logic                found;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    victim_way;
    logic [WAY_W-1:0]    way_sel;
    logic                is_hit;
    logic [AGE_W-1:0]    order;
    tag_row_t            tag_new;
    valid_row_t          valid_new;
    age_row_t            age_new;
    logic [31:0]         way_ext;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            match[w] = in_use[w] && (rd_tag_reg[w] == tag_reg);
        end
        found = |match;

        // first matching way
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
        end

        // oldest way in use, highest index on ties
        for (int i = 0; i < MAX_WAYS; i++) begin
            victim[i] = in_use[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (in_use[j] && j < i && rd_age_reg[i] < rd_age_reg[j]) begin
                    victim[i] = 1'b0;
                end
                if (in_use[j] && j > i && rd_age_reg[i] <= rd_age_reg[j]) begin
                    victim[i] = 1'b0;
                end
            end
        end
        victim_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (victim[w]) begin
                victim_way = WAY_W'(w);
            end
        end

        way_sel = found ? hit_way : victim_way;
        is_hit  = found && rd_valid_reg[hit_way];

        // refill on a miss
        tag_new   = rd_tag_reg;
        valid_new = rd_valid_reg;
        if (!is_hit) begin
            tag_new[way_sel]   = tag_reg;
            valid_new[way_sel] = 1'b1;
        end

        // used way to age zero, younger ways age by one
        order = rd_age_reg[way_sel];
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == way_sel) begin
                age_new[w] = '0;
            end else if (in_use[w] && rd_age_reg[w] < order) begin
                age_new[w] = rd_age_reg[w] + AGE_W'(1);
            end else begin
                age_new[w] = rd_age_reg[w];
            end
        end

        way_ext = 32'(way_sel);
    end

    // initial row after reset: ages equal way index
    age_row_t age_init;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            age_init[w] = AGE_W'(w);
        end
    end

    // sweep pointer for the reset and clear passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.init_wr || cmd.clr_wr) begin
            if (sweep_reg == SET_W'(LAST_SET)) begin
                sweep_reg <= '0;
            end else begin
                sweep_reg <= sweep_reg + SET_W'(1);
            end
        end
    end

    // word latch
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            set_reg <= set_idx;
            tag_reg <= tag_in;
        end
    end

    // tag memory
    always_ff @(posedge aclk) begin
        if (cmd.init_wr) begin
            tag_mem[sweep_reg] <= '0;
        end else if (cmd.commit_access) begin
            tag_mem[set_reg] <= tag_new;
        end
        if (cmd.capture) begin
            rd_tag_reg <= tag_mem[set_idx];
        end
    end

    // valid memory
    always_ff @(posedge aclk) begin
        if (cmd.init_wr || cmd.clr_wr) begin
            valid_mem[sweep_reg] <= '0;
        end else if (cmd.commit_access) begin
            valid_mem[set_reg] <= valid_new;
        end
        if (cmd.capture) begin
            rd_valid_reg <= valid_mem[set_idx];
        end
    end

    // age memory
    always_ff @(posedge aclk) begin
        if (cmd.init_wr) begin
            age_mem[sweep_reg] <= age_init;
        end else if (cmd.commit_access) begin
            age_mem[set_reg] <= age_new;
        end
        if (cmd.capture) begin
            rd_age_reg <= age_mem[set_idx];
        end
    end

    // saturating counters
    always_comb begin
        misses_next = misses_reg;
        if (cmd.commit_access && !is_hit && misses_reg != '1) begin
            misses_next = misses_reg + CNT_W'(1);
        end
        refs_next = refs_reg;
        if ((cmd.commit_access || cmd.commit_plain) && refs_reg != '1) begin
            refs_next = refs_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            misses_reg <= '0;
            refs_reg   <= '0;
        end else begin
            misses_reg <= misses_next;
            refs_reg   <= refs_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit_access || cmd.commit_plain) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_access || cmd.commit_plain) begin
            m_hit_reg             <= cmd.commit_access && is_hit;
            m_way_used_reg        <= cmd.commit_access ? way_ext[OUT_WAY_W-1:0] : '0;
            m_miss_count_reg      <= misses_next;
            m_reference_count_reg <= refs_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_way_used        = m_way_used_reg;
    assign m_miss_count      = m_miss_count_reg;
    assign m_reference_count = m_reference_count_reg;

    // status to the controller
    always_comb begin
        status            = '0;
        status.act_access = (s_action == ACT_ACCESS);
        status.act_clear  = (s_action == ACT_CLEAR);
        status.sweep_last = (sweep_reg == SET_W'(LAST_SET));
        status.out_free   = !m_valid_reg || m_ready;
    end

endmodule

FILE: rtl/set_assoc_cache_lru_tags_unit.sv
// Tag store of a set-associative cache with true LRU kept as per-way ages.
// Each input word is an access (address split into offset, set index, tag),
// a no-op or a clear of all valid bits; each word yields one result word with
// hit, way used and the saturating miss and reference counts. Tags, valid bits
// and ages live in one row per set; an access reads its set row in the cycle it
// is taken, then compares, picks the victim and writes the row back once the
// result register is free. s_ready stays low until a word's result is loaded,
// so no new word is taken before then. A clear sweeps the valid rows one set a
// cycle. After reset the block runs an initialization pass over all MAX_SETS
// sets (tags zero, lines invalid, ages set to way index) with s_ready low;
// configuration writes are taken during that pass. Results sit in an output
// register, so a stalled result holds the block only when the next result is
// ready to load. Registers: 0 offset_bits, 1 set_bits, 2 ways_in_use; the user
// must write them only while the block is idle; it does not enforce this.
module set_assoc_cache_lru_tags_unit #(
    parameter int MAX_WAYS  = sac_lru_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS  = sac_lru_pkg::DEF_MAX_SETS,
    parameter int ADDR_BITS = sac_lru_pkg::DEF_ADDR_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sac_lru_pkg::ACT_W-1:0]        s_action,
    input  logic [sac_lru_pkg::IN_ADDR_W-1:0]    s_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [sac_lru_pkg::OUT_WAY_W-1:0]    m_way_used,
    output logic [sac_lru_pkg::CNT_W-1:0]        m_miss_count,
    output logic [sac_lru_pkg::CNT_W-1:0]        m_reference_count,
    input  logic                                cfg_wr_en,
    input  logic [sac_lru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sac_lru_pkg::CFG_W-1:0]        cfg_data
);
    import sac_lru_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    sac_lru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // set rows, compare and counters
    sac_lru_dp #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_action          (s_action),
        .s_address         (s_address),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_way_used        (m_way_used),
        .m_miss_count      (m_miss_count),
        .m_reference_count (m_reference_count)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import sac_lru_pkg::*;

    localparam int MAX_WAYS     = DEF_MAX_WAYS;
    localparam int MAX_SETS     = DEF_MAX_SETS;
    localparam int LINES        = MAX_WAYS * MAX_SETS;
    localparam int SET_BITS_TOP = $clog2(MAX_SETS);
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 204;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;

    // action codes the package leaves unnamed
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    // register settings per phase, extremes included
    localparam logic [CFG_W-1:0] PHASE_OFFSET [PHASES] = '{4, 0, 15, 12, 0, 2, 6, 7};
    localparam logic [CFG_W-1:0] PHASE_SETS   [PHASES] = '{4, 0, 15, 8, 8, 3, 1, 5};
    localparam logic [CFG_W-1:0] PHASE_WAYS   [PHASES] = '{4, 1, 15, 8, 0, 2, 3, 7};

    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way_used;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     reference_count;
    } lookup_t;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [IN_ADDR_W-1:0] address;
        logic                 given;
        logic                 hit;
        logic [OUT_WAY_W-1:0] way_used;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     reference_count;
    } stim_row_t;

    // directed words, default registers: offset 4, index 4, 4 ways
    localparam int ROWS = 22;
    localparam stim_row_t DIRECTED_ROWS [ROWS] = '{
        '{ACT_ACCESS, 32'h0000_0000, 1'b1, 1'b0, 3'd0, 32'd1, 32'd1},
        '{ACT_ACCESS, 32'h0000_0000, 1'b1, 1'b1, 3'd0, 32'd1, 32'd2},
        '{ACT_NOP,    32'h0000_0000, 1'b1, 1'b0, 3'd0, 32'd1, 32'd3},
        '{ACT_SPARE,  32'hFFFF_FFFF, 1'b1, 1'b0, 3'd0, 32'd1, 32'd4},
        '{ACT_ACCESS, 32'h0000_0100, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h0000_0200, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h0000_0300, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h0000_0400, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h0000_0108, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h0000_0010, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'hFFFF_FFF0, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h8000_0000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h0000_0400, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'hAAAA_AAAA, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h5555_5555, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_ACCESS, 32'h0000_00F0, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_CLEAR,  32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{ACT_NOP,    32'h1234_5678, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [ACT_W-1:0]     s_action;
    logic [IN_ADDR_W-1:0] s_address;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_hit;
    logic [OUT_WAY_W-1:0] m_way_used;
    logic [CNT_W-1:0]     m_miss_count;
    logic [CNT_W-1:0]     m_reference_count;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // shadow of the tag store and its registers
    logic [31:0]      tag_mem   [LINES];
    logic             valid_mem [LINES];
    logic [2:0]       age_mem   [LINES];
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] ref_total;
    logic [CFG_W-1:0] cur_offset_bits;
    logic [CFG_W-1:0] cur_set_bits;
    logic [CFG_W-1:0] cur_ways;

    lookup_t     pending_results [$];
    int unsigned mismatches;
    int unsigned results_taken;
    logic        send_burst;

    set_assoc_cache_lru_tags_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_address         (s_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_way_used        (m_way_used),
        .m_miss_count      (m_miss_count),
        .m_reference_count (m_reference_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // index width clipped to the sets that exist
    function automatic int unsigned eff_set_bits();
        return (cur_set_bits > SET_BITS_TOP) ? SET_BITS_TOP : cur_set_bits;
    endfunction

    // ways in use clipped to 1..MAX_WAYS
    function automatic int unsigned eff_ways();
        if (cur_ways == 0)
            return 1;
        return (cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways;
    endfunction

    // lookup, replacement and age update of one word
    function automatic lookup_t lookup_and_age(input logic [ACT_W-1:0] act,
                                               input logic [IN_ADDR_W-1:0] addr);
        lookup_t     r;
        int unsigned ob;
        int unsigned sb;
        int unsigned nw;
        int unsigned base;
        int unsigned way;
        int unsigned i;
        logic [31:0] set_idx;
        logic [31:0] tag;
        logic        found;
        logic [2:0]  best;
        logic [2:0]  order;
        r = '0;
        way = 0;
        if (act == ACT_ACCESS) begin
            ob = cur_offset_bits;
            sb = eff_set_bits();
            nw = eff_ways();
            set_idx = (addr >> ob) & ((32'd1 << sb) - 32'd1);
            tag = addr >> (ob + sb);
            base = set_idx * MAX_WAYS;
            found = 1'b0;
            // first way in use with a matching tag
            for (i = 0; i < nw; i++) begin
                if (!found && tag_mem[base + i] == tag) begin
                    found = 1'b1;
                    way = i;
                end
            end
            if (found && valid_mem[base + way]) begin
                r.hit = 1'b1;
            end else begin
                // miss: refill the matched way, or on no match the oldest way, highest index on ties
                if (!found) begin
                    best = 3'd0;
                    for (i = 0; i < nw; i++) begin
                        if (age_mem[base + i] >= best) begin
                            best = age_mem[base + i];
                            way = i;
                        end
                    end
                end
                tag_mem[base + way] = tag;
                valid_mem[base + way] = 1'b1;
                if (miss_total != '1)
                    miss_total++;
            end
            // used way becomes youngest, younger ways age
            order = age_mem[base + way];
            for (i = 0; i < nw; i++) begin
                if (age_mem[base + i] < order)
                    age_mem[base + i]++;
            end
            age_mem[base + way] = 3'd0;
        end else if (act == ACT_CLEAR) begin
            for (i = 0; i < LINES; i++)
                valid_mem[i] = 1'b0;
        end
        if (ref_total != '1)
            ref_total++;
        r.way_used = way[OUT_WAY_W-1:0];
        r.miss_count = miss_total;
        r.reference_count = ref_total;
        return r;
    endfunction

    // address biased toward a few sets and tags so that hits and evictions occur
    function automatic logic [IN_ADDR_W-1:0] pick_address();
        int unsigned ob;
        int unsigned sb;
        int unsigned nw;
        logic [31:0] a;
        logic [31:0] set_sel;
        ob = cur_offset_bits;
        sb = eff_set_bits();
        nw = eff_ways();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        set_sel = $urandom_range(0, ((1 << sb) > 4) ? 3 : (1 << sb) - 1);
        a = $urandom_range(0, nw + 1);
        a = (a << (ob + sb)) | (set_sel << ob) | ($urandom() & ((32'd1 << ob) - 32'd1));
        return a;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    // offer one word, then queue what it should produce
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [IN_ADDR_W-1:0] addr,
                             input logic given, input lookup_t typed_result);
        int unsigned gap;
        lookup_t     predicted;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        predicted = lookup_and_age(act, addr);
        pending_results.push_back(given ? typed_result : predicted);
    endtask

    // sender stops until every queued result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] sb,
                              input logic [CFG_W-1:0] nw);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OFFSET_BITS;
        cfg_data <= ob;
        @(posedge aclk);
        cfg_index <= REG_SET_BITS;
        cfg_data <= sb;
        @(posedge aclk);
        cfg_index <= REG_WAYS_IN_USE;
        cfg_data <= nw;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_offset_bits = ob;
        cur_set_bits = sb;
        cur_ways = nw;
    endtask

    // stimulus
    initial begin
        int unsigned p;
        int unsigned n;
        int unsigned pick;
        int          r;
        logic [ACT_W-1:0] act;
        stim_row_t   row;
        for (r = 0; r < LINES; r++) begin
            tag_mem[r] = '0;
            valid_mem[r] = 1'b0;
            age_mem[r] = 3'(r % MAX_WAYS);
        end
        miss_total = '0;
        ref_total = '0;
        cur_offset_bits = RST_OFFSET_BITS;
        cur_set_bits = RST_SET_BITS;
        cur_ways = RST_WAYS_IN_USE;
        mismatches = 0;
        send_burst = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_ACCESS;
        s_address = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_OFFSET_BITS;
        cfg_data = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words
        for (r = 0; r < ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            send_word(row.action, row.address, row.given,
                      {row.hit, row.way_used, row.miss_count, row.reference_count});
        end

        // random phases, one register setting each
        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            write_regs(PHASE_OFFSET[p], PHASE_SETS[p], PHASE_WAYS[p]);
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n % 64 == 0)
                    send_burst = ($urandom_range(0, 3) == 0);
                // one pause mid-phase until the block has emptied
                if (p == 2 && n == 100)
                    wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    act = ACT_ACCESS;
                else if (pick < 93)
                    act = ACT_NOP;
                else if (pick < 95)
                    act = ACT_SPARE;
                else
                    act = ACT_CLEAR;
                send_word(act, pick_address(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // result side: random stalls, one long hold, field checks
    initial begin
        int unsigned gap;
        logic        take_burst;
        lookup_t     want;
        m_ready = 1'b0;
        results_taken = 0;
        take_burst = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 50 == 0)
                take_burst = ($urandom_range(0, 3) == 0);
            if (results_taken == HOLD_AT)
                gap = HOLD_CYCLES;
            else
                gap = take_burst ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with none pending", 32'd0, m_reference_count);
            end else begin
                want = pending_results.pop_front();
                if (m_hit !== want.hit)
                    flag_mismatch("hit", 32'(want.hit), 32'(m_hit));
                if (m_way_used !== want.way_used)
                    flag_mismatch("way_used", 32'(want.way_used), 32'(m_way_used));
                if (m_miss_count !== want.miss_count)
                    flag_mismatch("miss_count", want.miss_count, m_miss_count);
                if (m_reference_count !== want.reference_count)
                    flag_mismatch("reference_count", want.reference_count,
                                  m_reference_count);
            end
        end
    end

    // overall time limit
    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule
